// ===== hdl/rgbals_pkg.sv =====
// Shared types and constants for the RGB auto-level stretch unit.
package rgbals_pkg;

  localparam int CHANNELS   = 3;
  localparam int PIX_W      = 8;
  localparam int NUM_W      = 2 * PIX_W;
  localparam int DIV_STAGES = PIX_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_ZERO   = 8'd0;
  localparam logic [PIX_W-1:0] DEN_ONE    = 8'd1;

  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_APPLY   = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] den;
  } chan_job_t;

  typedef chan_job_t [CHANNELS-1:0] job_t;

endpackage

// ===== hdl/rgbals_front.sv =====
// Front end: keeps per-channel min/max and turns apply items into divide jobs.
module rgbals_front
  import rgbals_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic                in_first,
  input  pix_t                in_pix [CHANNELS],
  input  logic                q_full,
  output logic                q_push,
  output job_t                q_job
);

  pix_t min_r [CHANNELS];
  pix_t max_r [CHANNELS];
  pix_t min_nxt [CHANNELS];
  pix_t max_nxt [CHANNELS];
  logic acc;
  logic meas_acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign meas_acc = acc && (in_action == ACT_MEASURE);
  assign q_push   = acc && (in_action == ACT_APPLY);

  always_comb begin
    pix_t base_min;
    pix_t base_max;
    pix_t c;
    pix_t lo;
    pix_t hi;
    pix_t diff;
    for (int i = 0; i < CHANNELS; i++) begin
      c        = in_pix[i];
      lo       = min_r[i];
      hi       = max_r[i];
      base_min = in_first ? FULL_SCALE : lo;
      base_max = in_first ? PIX_ZERO : hi;
      min_nxt[i] = (c < base_min) ? c : base_min;
      max_nxt[i] = (c > base_max) ? c : base_max;
      diff = c - lo;
      if (hi <= lo || c <= lo) begin
        q_job[i].num = '0;
        q_job[i].den = DEN_ONE;
      end else if (c >= hi) begin
        q_job[i].num = {PIX_ZERO, FULL_SCALE};
        q_job[i].den = DEN_ONE;
      end else begin
        // diff * 255
        q_job[i].num = {diff, PIX_ZERO} - {PIX_ZERO, diff};
        q_job[i].den = hi - lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        min_r[i] <= FULL_SCALE;
        max_r[i] <= PIX_ZERO;
      end
    end else if (meas_acc) begin
      for (int i = 0; i < CHANNELS; i++) begin
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
      end
    end
  end

  a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    meas_acc |=> (min_r[0] <= max_r[0]) && (min_r[1] <= max_r[1]) &&
                 (min_r[2] <= max_r[2]))
    else $error("min above max after a measure item");

endmodule

// ===== hdl/rgbals_queue.sv =====
// Two-entry job queue between the front end and the divider pipeline.
module rgbals_queue
  import rgbals_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t       mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = (cnt_r == 2'(QUEUE_DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ===== hdl/rgbals_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, three channels.
module rgbals_div_pipe
  import rgbals_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  job_t q_job,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_pix [CHANNELS]
);

  localparam int LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] vld_r;
  logic [NUM_W-1:0]      rem_r [DIV_STAGES][CHANNELS];
  pix_t                  den_r [DIV_STAGES][CHANNELS];
  pix_t                  quo_r [DIV_STAGES][CHANNELS];
  logic [NUM_W-1:0]      rem_nxt [DIV_STAGES][CHANNELS];
  pix_t                  quo_nxt [DIV_STAGES][CHANNELS];
  logic [NUM_W-1:0]      rem_in [DIV_STAGES][CHANNELS];
  pix_t                  den_in [DIV_STAGES][CHANNELS];
  pix_t                  quo_in [DIV_STAGES][CHANNELS];
  logic                  adv;

  assign adv   = !vld_r[LAST] || out_ready;
  assign q_pop = adv && !q_empty;

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int K = DIV_STAGES - 1 - s;
      if (s == 0) begin : g_head
        always_comb begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            rem_in[s][ch] = q_job[ch].num;
            den_in[s][ch] = q_job[ch].den;
            quo_in[s][ch] = PIX_ZERO;
          end
        end
      end else begin : g_body
        always_comb begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            rem_in[s][ch] = rem_r[s-1][ch];
            den_in[s][ch] = den_r[s-1][ch];
            quo_in[s][ch] = quo_r[s-1][ch];
          end
        end
      end

      always_comb begin
        logic [NUM_W-1:0] dsh;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          dsh = {PIX_ZERO, den_in[s][ch]} << K;
          rem_nxt[s][ch] = rem_in[s][ch];
          quo_nxt[s][ch] = quo_in[s][ch];
          if (rem_in[s][ch] >= dsh) begin
            rem_nxt[s][ch]    = rem_in[s][ch] - dsh;
            quo_nxt[s][ch][K] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            rem_r[s][ch] <= rem_nxt[s][ch];
            den_r[s][ch] <= den_in[s][ch];
            quo_r[s][ch] <= quo_nxt[s][ch];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], !q_empty};
    end
  end

  assign out_valid = vld_r[LAST];
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      out_pix[ch] = quo_r[LAST][ch];
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] |-> (rem_r[LAST][0] < NUM_W'(den_r[LAST][0])) &&
                    (rem_r[LAST][1] < NUM_W'(den_r[LAST][1])) &&
                    (rem_r[LAST][2] < NUM_W'(den_r[LAST][2])))
    else $error("divider remainder not below divisor");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && !out_ready) |=> $stable(vld_r) && !$past(q_pop))
    else $error("pipeline moved while stalled");

endmodule

// ===== hdl/rgb_auto_level_stretch_unit.sv =====
// Top level of the RGB auto-level (min-max) stretch unit.
//
//  channel  ports                                          dir   role
//  in       in_valid/in_ready, in_action, in_first,        in    measure or apply item
//           in_red, in_green, in_blue
//  out      out_valid/out_ready, out_red, out_green,       out   stretched pixel item
//           out_blue
//
// Sustained rate of one item per cycle while out_ready does not stall; measure
// items finish at acceptance. An apply item reaches out_valid via the queue, whose
// head feeds the first of the 8 divider stages, one quotient bit per stage.
// Synchronous active-low reset sets min to 255 and max to 0; no clearing pass.
// A stall on out_ready freezes the divider; the 2-entry queue then fills and
// drops in_ready.
module rgb_auto_level_stretch_unit
  import rgbals_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  input  logic in_first,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  pix_t in_pix  [CHANNELS];
  pix_t out_pix [CHANNELS];
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t push_job;
  job_t pop_job;

  assign in_pix[0] = in_red;
  assign in_pix[1] = in_green;
  assign in_pix[2] = in_blue;

  rgbals_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_action(in_action),
    .in_first (in_first),
    .in_pix   (in_pix),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rgbals_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_job),
    .empty    (q_empty)
  );

  rgbals_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pix  (out_pix)
  );

  assign out_red   = out_pix[0];
  assign out_green = out_pix[1];
  assign out_blue  = out_pix[2];

endmodule
